@@ sv/bfgr_pkg.sv @@
// shared constants, codes and types for the glyph row renderer
package bfgr_pkg;

   localparam int IMAGE_WORDS_DEF     = 4096;
   localparam int MAX_ROWS_DEF        = 32;
   localparam int MAX_GLYPH_WIDTH_DEF = 32;
   localparam int TABLE_ENTRIES       = 258;
   localparam int TABLE_AW            = $clog2(TABLE_ENTRIES);

   localparam logic [15:0] OW_MISSING = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_DRAW   = 3'd0,
      KIND_IMAGE  = 3'd1,
      KIND_LOC    = 3'd2,
      KIND_WIDTH  = 3'd3,
      KIND_HEIGHT = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ROW_WORDS   = 2'd0,
      CSR_RECT_HEIGHT = 2'd1,
      CSR_LAST_CHAR   = 2'd2,
      CSR_HAS_HEIGHT  = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HT,
      ST_HT_W,
      ST_HT_ALT,
      ST_OW,
      ST_OW_W,
      ST_OW_ALT,
      ST_LOC,
      ST_LOC_W,
      ST_LOC_N,
      ST_MOD,
      ST_ROW,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_OUT,
      ST_BASE
   } state_type;

endpackage

@@ sv/bfgr_ram.sv @@
// generic simple dual port ram with registered read
module bfgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bitmap_font_glyph_row_renderer_top.sv @@
// glyph row renderer: table lookups, then image word fetches per visible row
// sequence: table lookups (the height entry lookup and each missing glyph fallback add to
// them), one modulo step per store wrap of the location word, then per visible row three
// image word reads on the one read port; a hidden row reads no image words; each row is
// presented and held until it is taken
// requests: one at a time
// reset: synchronous, clears control and config registers; stores are loaded before use
module bitmap_font_glyph_row_renderer_top #(
   parameter int IMAGE_WORDS     = bfgr_pkg::IMAGE_WORDS_DEF,
   parameter int MAX_ROWS        = bfgr_pkg::MAX_ROWS_DEF,
   parameter int MAX_GLYPH_WIDTH = bfgr_pkg::MAX_GLYPH_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [11:0] req_index,
   input  logic [15:0] req_value,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_row_index,
   output logic signed [7:0] rsp_x_offset,
   output logic [31:0] rsp_row_bits,
   output logic [5:0]  rsp_pixel_width,
   output logic [7:0]  rsp_advance,
   output logic        rsp_clipped,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import bfgr_pkg::*;

   localparam int AW        = $clog2(IMAGE_WORDS);
   localparam int SW        = ((AW > 12) ? AW : 12) + 1;
   localparam int BW        = AW + 10;
   localparam int ROW_CAP   = (MAX_ROWS < 32) ? MAX_ROWS : 32;
   localparam int WIDTH_CAP = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;
   localparam logic [SW-1:0] IW_S = SW'(IMAGE_WORDS);
   localparam logic [BW-1:0] IW_B = BW'(IMAGE_WORDS);

   // config
   logic [8:0] row_words_ff;
   logic [5:0] rect_height_ff;
   logic [7:0] last_char_ff;
   logic       has_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_words_ff   <= 9'd1;
         rect_height_ff <= 6'd1;
         last_char_ff   <= 8'hFF;
         has_height_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_WORDS:   row_words_ff   <= csr_wdata;
            CSR_RECT_HEIGHT: rect_height_ff <= csr_wdata[5:0];
            CSR_LAST_CHAR:   last_char_ff   <= csr_wdata[7:0];
            CSR_HAS_HEIGHT:  has_height_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // datapath registers
   state_type         state_ff, state_in;
   logic [8:0]        char_ff, char_in;
   logic [7:0]        first_ff, first_in;
   logic [8:0]        end_ff, end_in;
   logic [7:0]        xo_ff, xo_in;
   logic [7:0]        adv_ff, adv_in;
   logic [15:0]       loc_ff, loc_in;
   logic [5:0]        pw_ff, pw_in;
   logic              clip_ff, clip_in;
   logic [11:0]       locw_ff, locw_in;
   logic [BW-1:0]     base_ff, base_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [15:0]       w0_ff, w0_in, w1_ff, w1_in;
   logic [4:0]        row_ff, row_in;
   logic [5:0]        rows_ff, rows_in;
   logic [4:0]        o_row_ff, o_row_in;
   logic [31:0]       o_bits_ff, o_bits_in;
   logic [7:0]        o_adv_ff, o_adv_in;
   logic              o_last_ff, o_last_in;

   // stores
   logic              img_we, loc_we, ow_we, ht_we;
   logic              img_re, loc_re, ow_re, ht_re;
   logic [AW-1:0]     img_raddr;
   logic [TABLE_AW-1:0] loc_raddr, ow_raddr, ht_raddr;
   logic [15:0]       img_rdata, loc_rdata, ow_rdata, ht_rdata;
   logic              load_ok_img, load_ok_tab, accept;

   assign accept      = req_valid && req_ready;
   assign load_ok_img = {5'd0, req_index} < 17'(IMAGE_WORDS);
   assign load_ok_tab = req_index < 12'(TABLE_ENTRIES);
   assign img_we = accept && req_kind == KIND_IMAGE && load_ok_img;
   assign loc_we = accept && req_kind == KIND_LOC && load_ok_tab;
   assign ow_we  = accept && req_kind == KIND_WIDTH && load_ok_tab;
   assign ht_we  = accept && req_kind == KIND_HEIGHT && load_ok_tab;

   bfgr_ram #(.WIDTH(16), .DEPTH(IMAGE_WORDS)) u_img (
      .clock, .wr_en(img_we), .wr_addr(AW'(req_index)), .wr_data(req_value),
      .rd_en(img_re), .rd_addr(img_raddr), .rd_data(img_rdata));
   bfgr_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_loc (
      .clock, .wr_en(loc_we), .wr_addr(TABLE_AW'(req_index)), .wr_data(req_value),
      .rd_en(loc_re), .rd_addr(loc_raddr), .rd_data(loc_rdata));
   bfgr_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_ow (
      .clock, .wr_en(ow_we), .wr_addr(TABLE_AW'(req_index)), .wr_data(req_value),
      .rd_en(ow_re), .rd_addr(ow_raddr), .rd_data(ow_rdata));
   bfgr_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_ht (
      .clock, .wr_en(ht_we), .wr_addr(TABLE_AW'(req_index)), .wr_data(req_value),
      .rd_en(ht_re), .rd_addr(ht_raddr), .rd_data(ht_rdata));

   logic [8:0]    alt_char;
   logic [16:0]   diff;
   logic [SW-1:0] start_sum, ptr_sum;
   logic [47:0]   window;
   logic [47:0]   shifted;
   logic [31:0]   pix_mask;
   logic          visible, is_last;

   assign alt_char  = {1'b0, last_char_ff} + 9'd1;
   assign diff      = {1'b0, loc_rdata} - {1'b0, loc_ff};
   assign start_sum = SW'(base_ff) + SW'(locw_ff);
   assign ptr_sum   = SW'(ptr_ff) + SW'(1);
   assign window    = {w0_ff, w1_ff, img_rdata};
   assign shifted   = window << loc_ff[3:0];
   assign pix_mask  = ~(32'hFFFF_FFFF >> pw_ff);
   assign visible   = ({3'd0, row_ff} >= first_ff) && ({4'd0, row_ff} < end_ff);
   assign is_last   = ({1'b0, row_ff} + 6'd1) == rows_ff;

   always_comb begin
      state_in  = state_ff;
      char_in   = char_ff;
      first_in  = first_ff;
      end_in    = end_ff;
      xo_in     = xo_ff;
      adv_in    = adv_ff;
      loc_in    = loc_ff;
      pw_in     = pw_ff;
      clip_in   = clip_ff;
      locw_in   = locw_ff;
      base_in   = base_ff;
      ptr_in    = ptr_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      row_in    = row_ff;
      rows_in   = rows_ff;
      o_row_in  = o_row_ff;
      o_bits_in = o_bits_ff;
      o_adv_in  = o_adv_ff;
      o_last_in = o_last_ff;
      img_re    = 1'b0;
      loc_re    = 1'b0;
      ow_re     = 1'b0;
      ht_re     = 1'b0;
      img_raddr = ptr_ff;
      loc_raddr = char_ff;
      ow_raddr  = char_ff;
      ht_raddr  = char_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind == KIND_DRAW) begin
               char_in = {1'b0, req_char_code};
               if (rect_height_ff == 6'd0) begin
                  rows_in = 6'd1;
               end else if (rect_height_ff > 6'(ROW_CAP)) begin
                  rows_in = 6'(ROW_CAP);
               end else begin
                  rows_in = rect_height_ff;
               end
               first_in = 8'd0;
               end_in   = {3'd0, rect_height_ff};
               state_in = has_height_ff ? ST_HT : ST_OW;
            end
         end
         ST_HT: begin
            ht_re    = 1'b1;
            state_in = ST_HT_W;
         end
         ST_HT_W: begin
            if (ht_rdata == 16'd0) begin
               // empty entry: fall back to the missing glyph's entry
               ht_re    = 1'b1;
               ht_raddr = alt_char;
               state_in = ST_HT_ALT;
            end else begin
               first_in = ht_rdata[15:8];
               end_in   = {1'b0, ht_rdata[15:8]} + {1'b0, ht_rdata[7:0]};
               state_in = ST_OW;
            end
         end
         ST_HT_ALT: begin
            first_in = ht_rdata[15:8];
            end_in   = {1'b0, ht_rdata[15:8]} + {1'b0, ht_rdata[7:0]};
            state_in = ST_OW;
         end
         ST_OW: begin
            ow_re    = 1'b1;
            state_in = ST_OW_W;
         end
         ST_OW_W: begin
            if (ow_rdata == OW_MISSING) begin
               char_in  = alt_char;
               ow_re    = 1'b1;
               ow_raddr = alt_char;
               state_in = ST_OW_ALT;
            end else begin
               xo_in    = ow_rdata[15:8];
               adv_in   = ow_rdata[7:0];
               state_in = ST_LOC;
            end
         end
         ST_OW_ALT: begin
            xo_in    = ow_rdata[15:8];
            adv_in   = ow_rdata[7:0];
            state_in = ST_LOC;
         end
         ST_LOC: begin
            loc_re   = 1'b1;
            state_in = ST_LOC_W;
         end
         ST_LOC_W: begin
            loc_in    = loc_rdata;
            loc_re    = 1'b1;
            loc_raddr = char_ff + 9'd1;
            state_in  = ST_LOC_N;
         end
         ST_LOC_N: begin
            if (diff[16]) begin
               pw_in   = 6'd0;
               clip_in = 1'b1;
            end else if (diff > 17'(WIDTH_CAP)) begin
               pw_in   = 6'(WIDTH_CAP);
               clip_in = 1'b1;
            end else begin
               pw_in   = diff[5:0];
               clip_in = 1'b0;
            end
            locw_in  = loc_ff[15:4];
            base_in  = '0;
            row_in   = 5'd0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            // word offset modulo store size, one subtract a cycle
            if (SW'(locw_ff) >= IW_S) begin
               locw_in = 12'(SW'(locw_ff) - IW_S);
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (visible) begin
               ptr_in   = (start_sum >= IW_S) ? AW'(start_sum - IW_S) : AW'(start_sum);
               state_in = ST_RD0;
            end else begin
               o_row_in  = row_ff;
               o_bits_in = 32'd0;
               o_adv_in  = is_last ? adv_ff : 8'd0;
               o_last_in = is_last;
               state_in  = ST_OUT;
            end
         end
         ST_RD0, ST_RD1, ST_RD2: begin
            img_re = 1'b1;
            ptr_in = (ptr_sum >= IW_S) ? AW'(ptr_sum - IW_S) : AW'(ptr_sum);
            if (state_ff == ST_RD1) begin
               w0_in = img_rdata;
            end
            if (state_ff == ST_RD2) begin
               w1_in = img_rdata;
            end
            unique case (state_ff)
               ST_RD0:  state_in = ST_RD1;
               ST_RD1:  state_in = ST_RD2;
               default: state_in = ST_RD3;
            endcase
         end
         ST_RD3: begin
            o_row_in  = row_ff;
            o_bits_in = shifted[47:16] & pix_mask;
            o_adv_in  = is_last ? adv_ff : 8'd0;
            o_last_in = is_last;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (o_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 5'd1;
                  base_in  = base_ff + BW'(row_words_ff);
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            if (base_ff >= IW_B) begin
               base_in = base_ff - IW_B;
            end else begin
               state_in = ST_ROW;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      first_ff  <= first_in;
      end_ff    <= end_in;
      xo_ff     <= xo_in;
      adv_ff    <= adv_in;
      loc_ff    <= loc_in;
      pw_ff     <= pw_in;
      clip_ff   <= clip_in;
      locw_ff   <= locw_in;
      base_ff   <= base_in;
      ptr_ff    <= ptr_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      row_ff    <= row_in;
      rows_ff   <= rows_in;
      o_row_ff  <= o_row_in;
      o_bits_ff <= o_bits_in;
      o_adv_ff  <= o_adv_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid       = state_ff == ST_OUT;
   assign rsp_row_index   = o_row_ff;
   assign rsp_x_offset    = xo_ff;
   assign rsp_row_bits    = o_bits_ff;
   assign rsp_pixel_width = pw_ff;
   assign rsp_advance     = o_adv_ff;
   assign rsp_clipped     = clip_ff;
   assign rsp_last        = o_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while a row is pending");
   a_adv_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> rsp_advance == 8'd0) else $error("advance before last row");
   a_width_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_width <= 6'(WIDTH_CAP)) else $error("pixel width over limit");
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready) else $error("not idle after last row");

endmodule

@@ sim/tb_top.sv @@
// testbench for the glyph row renderer: random and directed requests checked row by row
`timescale 1ns / 1ps

module tb_top;
   import bfgr_pkg::*;

   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
   localparam int STRIKE_WORDS = IMAGE_WORDS_DEF;
   localparam int ROW_LIMIT = 32;
   localparam int WIDTH_LIMIT = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 40;
   localparam int TAB_LOC = 0;
   localparam int TAB_OW = 1;
   localparam int TAB_HT = 2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] index;
      logic [15:0] value;
      logic [7:0]  char_code;
   } glyph_req_type;

   typedef struct packed {
      logic [4:0]        row_index;
      logic signed [7:0] x_offset;
      logic [31:0]       row_bits;
      logic [5:0]        pixel_width;
      logic [7:0]        advance;
      logic              clipped;
      logic              last;
   } glyph_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [11:0] req_index;
   logic [15:0] req_value;
   logic [7:0]  req_char_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_row_index;
   logic signed [7:0] rsp_x_offset;
   logic [31:0] rsp_row_bits;
   logic [5:0]  rsp_pixel_width;
   logic [7:0]  rsp_advance;
   logic        rsp_clipped;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;

   bitmap_font_glyph_row_renderer_top uut (.*);

   // register copies, shared by the request builder and the row predictor
   int unsigned cfg_row_words, cfg_rect_height, cfg_last_char, cfg_has_height;

   // predictor stores, updated as requests are accepted
   bit [15:0] strike_mem [STRIKE_WORDS];
   bit [15:0] table_mem [3][TABLE_ENTRIES];

   // builder shadow: which entries have been loaded so far
   bit        strike_loaded [STRIKE_WORDS];
   bit [15:0] table_shadow [3][TABLE_ENTRIES];
   bit        table_loaded [3][TABLE_ENTRIES];

   glyph_req_type pending_reqs[$];
   glyph_row_type expected_rows[$];

   int  mismatch_count;
   int  idle_cycles;
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  req_taken;
   bit  hold_go, hold_done;
   int  hold_cycles;

   always #10 clock = ~clock;

   function automatic logic [31:0] strike_row(int unsigned r, int unsigned loc,
                                              int unsigned pw);
      logic [31:0] bits;
      int unsigned pos, addr;
      bits = '0;
      for (int unsigned k = 0; k < pw; k++) begin
         pos = loc + k;
         addr = (r * cfg_row_words + (pos >> 4)) % STRIKE_WORDS;
         bits[31 - k] = strike_mem[addr][15 - (pos & 15)];
      end
      return bits;
   endfunction

   function automatic int unsigned clamp_rows(int unsigned n);
      if (n < 1) return 1;
      if (n > ROW_LIMIT) return ROW_LIMIT;
      return n;
   endfunction

   task automatic predict_request(glyph_req_type it);
      int unsigned c, v, vis_first, end_row, ow, loc, nloc, pw, rows;
      int diff;
      bit clip;
      glyph_row_type row;
      case (it.kind)
         KIND_IMAGE: strike_mem[it.index] = it.value;
         KIND_LOC, KIND_WIDTH, KIND_HEIGHT: begin
            if (it.index < TABLE_ENTRIES)
               table_mem[it.kind - KIND_LOC][it.index] = it.value;
         end
         KIND_DRAW: begin
            c = it.char_code;
            if (cfg_has_height != 0) begin
               v = table_mem[TAB_HT][c];
               if (v == 0) v = table_mem[TAB_HT][cfg_last_char + 1];
               vis_first = v >> 8;
               end_row = vis_first + (v & 8'hFF);
            end else begin
               vis_first = 0;
               end_row = cfg_rect_height;
            end
            ow = table_mem[TAB_OW][c];
            if (ow == OW_MISSING) begin
               c = cfg_last_char + 1;
               ow = table_mem[TAB_OW][c];
            end
            loc = table_mem[TAB_LOC][c];
            nloc = table_mem[TAB_LOC][c + 1];
            diff = int'(nloc) - int'(loc);
            clip = 1'b0;
            if (diff < 0) begin
               pw = 0;
               clip = 1'b1;
            end else if (diff > WIDTH_LIMIT) begin
               pw = WIDTH_LIMIT;
               clip = 1'b1;
            end else begin
               pw = diff;
            end
            rows = clamp_rows(cfg_rect_height);
            for (int unsigned r = 0; r < rows; r++) begin
               row.row_index = r[4:0];
               row.x_offset = ow[15:8];
               row.row_bits = (r >= vis_first && r < end_row) ? strike_row(r, loc, pw) : '0;
               row.pixel_width = pw[5:0];
               row.last = (r + 1 == rows);
               row.advance = row.last ? ow[7:0] : 8'd0;
               row.clipped = clip;
               expected_rows.push_back(row);
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_req(logic [2:0] kind, logic [11:0] idx, logic [15:0] val,
                           logic [7:0] chr);
      glyph_req_type it;
      it = '{kind: kind, index: idx, value: val, char_code: chr};
      pending_reqs.push_back(it);
      if (kind == KIND_IMAGE) begin
         strike_loaded[idx] = 1'b1;
      end else if ((kind == KIND_LOC || kind == KIND_WIDTH || kind == KIND_HEIGHT) &&
                   idx < TABLE_ENTRIES) begin
         table_shadow[kind - KIND_LOC][idx] = val;
         table_loaded[kind - KIND_LOC][idx] = 1'b1;
      end
   endtask

   function automatic logic [15:0] pick_entry(int t, int unsigned idx);
      int v;
      case (t)
         TAB_LOC: begin
            // mostly glyphs packed next to each other, some negative or wide
            if (idx > 0 && table_loaded[TAB_LOC][idx - 1] && $urandom_range(0, 7) != 0) begin
               v = int'(table_shadow[TAB_LOC][idx - 1]) + $urandom_range(0, 40) - 4;
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
            end else if ($urandom_range(0, 5) == 0) begin
               v = $urandom_range(0, 65535);
            end else begin
               v = $urandom_range(0, 3000);
            end
            return v[15:0];
         end
         TAB_OW: begin
            if ($urandom_range(0, 5) == 0) return OW_MISSING;
            return 16'($urandom_range(0, 65535));
         end
         default: begin
            if ($urandom_range(0, 4) == 0) return 16'd0;
            if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
            v = ($urandom_range(0, cfg_rect_height) << 8) | $urandom_range(0, cfg_rect_height + 2);
            return v[15:0];
         end
      endcase
   endfunction

   task automatic load_if_missing(int t, int unsigned idx);
      if (!table_loaded[t][idx])
         push_req(3'(KIND_LOC + t), idx[11:0], pick_entry(t, idx), 8'($urandom_range(0, 255)));
   endtask

   // loads whatever the glyph would read that was never loaded, then the draw
   task automatic queue_draw(int unsigned chr);
      int unsigned c, v, vis_first, end_row, loc, pw, rows, pos, addr;
      int diff;
      c = chr;
      vis_first = 0;
      end_row = cfg_rect_height;
      if (cfg_has_height != 0) begin
         load_if_missing(TAB_HT, c);
         v = table_shadow[TAB_HT][c];
         if (v == 0) begin
            load_if_missing(TAB_HT, cfg_last_char + 1);
            v = table_shadow[TAB_HT][cfg_last_char + 1];
         end
         vis_first = v >> 8;
         end_row = vis_first + (v & 8'hFF);
      end
      load_if_missing(TAB_OW, c);
      if (table_shadow[TAB_OW][c] == OW_MISSING) begin
         c = cfg_last_char + 1;
         load_if_missing(TAB_OW, c);
      end
      load_if_missing(TAB_LOC, c);
      load_if_missing(TAB_LOC, c + 1);
      loc = table_shadow[TAB_LOC][c];
      diff = int'(table_shadow[TAB_LOC][c + 1]) - int'(loc);
      pw = (diff < 0) ? 0 : (diff > WIDTH_LIMIT) ? WIDTH_LIMIT : diff;
      rows = clamp_rows(cfg_rect_height);
      for (int unsigned r = 0; r < rows; r++) begin
         if (r >= vis_first && r < end_row) begin
            for (int unsigned k = 0; k < pw; k++) begin
               pos = loc + k;
               addr = (r * cfg_row_words + (pos >> 4)) % STRIKE_WORDS;
               if (!strike_loaded[addr])
                  push_req(KIND_IMAGE, addr[11:0], 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
            end
         end
      end
      push_req(KIND_DRAW, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
               chr[7:0]);
   endtask

   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: push_req(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                     12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
         1: push_req(KIND_IMAGE, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
         default: push_req(3'($urandom_range(KIND_LOC, KIND_HEIGHT)),
                           12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data[8:0];
      case (idx)
         CSR_ROW_WORDS:   cfg_row_words = data & 9'h1FF;
         CSR_RECT_HEIGHT: cfg_rect_height = data & 6'h3F;
         CSR_LAST_CHAR:   cfg_last_char = data & 8'hFF;
         CSR_HAS_HEIGHT:  cfg_has_height = data & 1;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_registers(int unsigned rw, int unsigned rh, int unsigned lc,
                                int unsigned ht);
      write_csr(CSR_ROW_WORDS, rw);
      write_csr(CSR_RECT_HEIGHT, rh);
      write_csr(CSR_LAST_CHAR, lc);
      write_csr(CSR_HAS_HEIGHT, ht);
   endtask

   task automatic run_random(int quota, int send_pct, int stall_pct);
      int start;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < quota) begin
         if ($urandom_range(0, 3) != 0)
            // favor a few characters so that their entries get reused
            queue_draw($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
         else
            queue_noise();
      end
   endtask

   task automatic wait_drained();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rows.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver and response ready, changed on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               glyph_req_type it;
               it = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_kind <= it.kind;
               req_index <= it.index;
               req_value <= it.value;
               req_char_code <= it.char_code;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !(hold_go && !hold_done) && $urandom_range(0, 99) >= rsp_stall_pct;
      end
   end

   // long receiver hold-off while requests keep coming
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == HOLD_CYCLES) hold_done <= 1'b1;
      end
   end

   // monitor: predicts on accepted requests, checks accepted rows
   always @(posedge clock) begin
      glyph_row_type got, want;
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (req_valid && req_ready) begin
            predict_request('{kind: req_kind, index: req_index, value: req_value,
                              char_code: req_char_code});
            req_taken = 1'b1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            got = '{rsp_row_index, rsp_x_offset, rsp_row_bits, rsp_pixel_width,
                    rsp_advance, rsp_clipped, rsp_last};
            if (expected_rows.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected row: %p", got);
            end else begin
               want = expected_rows.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("row mismatch: expected %p got %p", want, got);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ROW_WORDS;
      csr_wdata = '0;
      cfg_row_words = 1;
      cfg_rect_height = 1;
      cfg_last_char = 255;
      cfg_has_height = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: store extremes, ignored loads, missing glyph at the top entry,
      // negative and too wide glyphs, zero height entry, hidden rows
      set_registers(256, 4, 255, 1);
      push_req(KIND_IMAGE, 12'hFFF, 16'hFFFF, 8'hFF);
      push_req(KIND_IMAGE, 12'h000, 16'h0000, 8'h00);
      push_req(KIND_LOC, 12'hFFF, 16'hA5A5, 8'h5A);
      push_req(KIND_HEIGHT, 12'(TABLE_ENTRIES), 16'h1234, 8'h00);
      push_req(KIND_UNUSED_LO, 12'h0AA, 16'h5555, 8'hAA);
      push_req(KIND_UNUSED_HI, 12'hF55, 16'hAAAA, 8'h55);
      push_req(KIND_WIDTH, 255, OW_MISSING, 8'h00);
      push_req(KIND_WIDTH, 256, 16'h80FF, 8'h00);
      push_req(KIND_LOC, 256, 16'hFFFA, 8'h00);
      push_req(KIND_LOC, 257, 16'hFFFF, 8'h00);
      push_req(KIND_HEIGHT, 255, 16'h0004, 8'h00);
      queue_draw(255);
      push_req(KIND_WIDTH, 10, 16'h7F00, 8'h00);
      push_req(KIND_LOC, 10, 16'd100, 8'h00);
      push_req(KIND_LOC, 11, 16'd50, 8'h00);
      push_req(KIND_HEIGHT, 10, 16'h0104, 8'h00);
      queue_draw(10);
      push_req(KIND_WIDTH, 20, 16'h0108, 8'h00);
      push_req(KIND_LOC, 20, 16'd0, 8'h00);
      push_req(KIND_LOC, 21, 16'd40, 8'h00);
      push_req(KIND_HEIGHT, 20, 16'h0000, 8'h00);
      push_req(KIND_HEIGHT, 256, 16'h0203, 8'h00);
      queue_draw(20);
      push_req(KIND_WIDTH, 30, 16'h0010, 8'h00);
      push_req(KIND_LOC, 30, 16'd16, 8'h00);
      push_req(KIND_LOC, 31, 16'd48, 8'h00);
      push_req(KIND_HEIGHT, 30, 16'h03FF, 8'h00);
      queue_draw(30);
      push_req(KIND_HEIGHT, 0, 16'hFF01, 8'h00);
      queue_draw(0);
      wait_drained();

      set_registers(1, 8, 100, 0);
      run_random(90, 0, 0);
      wait_drained();

      set_registers(3, 32, 200, 1);
      run_random(90, 68, 0);
      wait_drained();

      set_registers(256, 5, 0, 1);
      run_random(90, 0, 68);
      hold_go = 1'b1;
      wait_drained();

      // rectangle height above the row limit saturates
      set_registers(2, 63, 255, 0);
      run_random(70, 18, 18);
      wait_drained();

      // zero rectangle height still emits one row
      set_registers(1, 0, 17, 1);
      run_random(90, 0, 0);
      wait_drained();

      if (mismatch_count == 0 && expected_rows.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/bfgr_pkg.sv
sv/bfgr_ram.sv
sv/bitmap_font_glyph_row_renderer_top.sv
sim/tb_top.sv
